// File: design/xtt_pkg.sv
package xtt_pkg;

	// Default sizing, handed to the top level parameters.
	localparam int DEF_MAX_LEN   = 4096;
	localparam int DEF_MAX_DEPTH = 64;

	// A single byte can cause at most this many results.
	localparam int MAX_RES   = 3;
	localparam int RES_CNT_W = $clog2(MAX_RES + 1);

	// Result queue depth.
	localparam int QDEPTH = 4;

	// Width of the reported nesting depth.
	localparam int DEPTH_OUT_W = 7;

	// Event codes.
	localparam logic [3:0] EV_CONTENT    = 4'd0;
	localparam logic [3:0] EV_TAG_BYTE   = 4'd1;
	localparam logic [3:0] EV_OPEN_END   = 4'd2;
	localparam logic [3:0] EV_SELF_CLOSE = 4'd3;
	localparam logic [3:0] EV_END_TAG    = 4'd4;
	localparam logic [3:0] EV_COMMENT    = 4'd5;
	localparam logic [3:0] EV_DECL       = 4'd6;
	localparam logic [3:0] EV_EMPTY      = 4'd7;
	localparam logic [3:0] EV_ERROR      = 4'd8;

	// Error codes.
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_TAG_LEN   = 3'd1;
	localparam logic [2:0] ERR_CONT_LEN  = 3'd2;
	localparam logic [2:0] ERR_BAD_DECL  = 3'd3;
	localparam logic [2:0] ERR_UNMATCHED = 3'd4;
	localparam logic [2:0] ERR_TOO_DEEP  = 3'd5;

	// Tag classes, fixed by the first byte after the opening bracket.
	localparam logic [2:0] TC_NONE    = 3'd0;
	localparam logic [2:0] TC_ELEM    = 3'd1;
	localparam logic [2:0] TC_COMMENT = 3'd2;
	localparam logic [2:0] TC_DECL    = 3'd3;
	localparam logic [2:0] TC_END     = 3'd4;
	localparam logic [2:0] TC_EMPTY   = 3'd5;

	// Declaration match progress: all four bytes matched, or failed.
	localparam logic [2:0] DECL_FULL = 3'd4;
	localparam logic [2:0] DECL_FAIL = 3'd5;

	// Characters of interest.
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;

	typedef struct packed {
		logic [7:0] byte_req;
		logic       last;
	} in_beat_t;

	typedef struct packed {
		logic [3:0]             event_res;
		logic [7:0]             value;
		logic                   kept;
		logic [DEPTH_OUT_W-1:0] depth;
		logic [2:0]             error_code;
		logic                   last_of_run;
	} out_beat_t;

	// Lower-case an ASCII letter, leave everything else alone.
	function automatic logic [7:0] fold_case(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= CH_UP_A && b <= CH_UP_Z) begin
			r = b + 8'd32;
		end
		return r;
	endfunction

	// Expected bytes of the declaration prefix "xml ".
	function automatic logic [7:0] decl_char(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0: r = 8'h78;
			2'd1: r = 8'h6D;
			2'd2: r = 8'h6C;
			default: r = 8'h20;
		endcase
		return r;
	endfunction

	// Build one result beat; last_of_run is filled in later.
	function automatic out_beat_t make_res(
		input logic [3:0]             ev,
		input logic [7:0]             val,
		input logic                   kept,
		input logic [2:0]             code,
		input logic [DEPTH_OUT_W-1:0] dep
	);
		out_beat_t r;
		r.event_res   = ev;
		r.value       = val;
		r.kept        = kept;
		r.depth       = dep;
		r.error_code  = code;
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage

// File: design/xtt_core.sv
module xtt_core import xtt_pkg::*; #(
	parameter int MAX_LEN   = DEF_MAX_LEN,
	parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  in_beat_t             beat,
	output out_beat_t            res [MAX_RES],
	output logic [RES_CNT_W-1:0] res_count
);

	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int DEP_W = $clog2(MAX_DEPTH + 1);

	// Parser state.
	logic             in_tag_q,     in_tag_d;
	logic [LEN_W-1:0] tag_len_q,    tag_len_d;
	logic [LEN_W-1:0] cont_len_q,   cont_len_d;
	logic [DEP_W-1:0] nest_q,       nest_d;
	logic [2:0]       tag_class_q,  tag_class_d;
	logic [7:0]       held_byte_q,  held_byte_d;
	logic             held_valid_q, held_valid_d;
	logic [2:0]       decl_match_q, decl_match_d;
	logic             err_q,        err_d;
	logic [2:0]       err_code_q,   err_code_d;

	out_beat_t            list [MAX_RES];
	logic [RES_CNT_W-1:0] cnt;
	logic                 do_close;
	logic [7:0]           b;
	logic [2:0]           pos;
	logic [2:0]           pos_m1;

	// Next state and result list for one byte.
	always_comb begin
		in_tag_d     = in_tag_q;
		tag_len_d    = tag_len_q;
		cont_len_d   = cont_len_q;
		nest_d       = nest_q;
		tag_class_d  = tag_class_q;
		held_byte_d  = held_byte_q;
		held_valid_d = held_valid_q;
		decl_match_d = decl_match_q;
		err_d        = err_q;
		err_code_d   = err_code_q;
		for (int k = 0; k < MAX_RES; k++) begin
			list[k] = '0;
		end
		cnt      = '0;
		do_close = 1'b0;
		b        = beat.byte_req;
		pos      = tag_len_q[2:0];
		pos_m1   = pos - 3'd1;

		// Byte handling in the current mode.
		if (err_q) begin
			list[cnt] = make_res(EV_ERROR, 8'd0, 1'b0, err_code_q, DEPTH_OUT_W'(nest_d));
			cnt = cnt + 1'b1;
		end else if (!in_tag_q) begin
			if (b == CH_LT) begin
				in_tag_d     = 1'b1;
				tag_len_d    = '0;
				cont_len_d   = '0;
				tag_class_d  = TC_NONE;
				held_valid_d = 1'b0;
				held_byte_d  = '0;
				decl_match_d = '0;
			end else if (cont_len_q >= LEN_W'(MAX_LEN)) begin
				err_d      = 1'b1;
				err_code_d = ERR_CONT_LEN;
				list[cnt] = make_res(EV_ERROR, 8'd0, 1'b0, ERR_CONT_LEN, DEPTH_OUT_W'(nest_d));
				cnt = cnt + 1'b1;
			end else begin
				cont_len_d = cont_len_q + 1'b1;
				list[cnt] = make_res(EV_CONTENT, b, nest_q != '0, ERR_NONE,
					DEPTH_OUT_W'(nest_d));
				cnt = cnt + 1'b1;
			end
		end else if (b == CH_GT) begin
			do_close = 1'b1;
		end else if (tag_len_q >= LEN_W'(MAX_LEN)) begin
			err_d      = 1'b1;
			err_code_d = ERR_TAG_LEN;
			list[cnt] = make_res(EV_ERROR, 8'd0, 1'b0, ERR_TAG_LEN, DEPTH_OUT_W'(nest_d));
			cnt = cnt + 1'b1;
		end else begin
			tag_len_d = tag_len_q + 1'b1;
			if (tag_len_q == '0) begin
				// The first tag byte picks the class.
				if (b == CH_BANG) begin
					tag_class_d = TC_COMMENT;
				end else if (b == CH_QUEST) begin
					tag_class_d = TC_DECL;
				end else if (b == CH_SLASH) begin
					tag_class_d = TC_END;
				end else if (b == CH_NUL) begin
					tag_class_d = TC_EMPTY;
				end else begin
					tag_class_d  = TC_ELEM;
					held_byte_d  = b;
					held_valid_d = 1'b1;
				end
			end else if (tag_class_q == TC_ELEM) begin
				// Element bytes go out one byte late.
				if (held_valid_q) begin
					list[cnt] = make_res(EV_TAG_BYTE, held_byte_q, 1'b0, ERR_NONE,
						DEPTH_OUT_W'(nest_d));
					cnt = cnt + 1'b1;
				end
				held_byte_d  = b;
				held_valid_d = 1'b1;
			end else if (tag_class_q == TC_DECL && tag_len_q <= LEN_W'(4)) begin
				if (decl_match_q == pos_m1 && fold_case(b) == decl_char(pos_m1[1:0])) begin
					decl_match_d = pos;
				end else begin
					decl_match_d = DECL_FAIL;
				end
			end
		end

		// A final byte closes a tag that is still open.
		if (beat.last && in_tag_d && !err_d) begin
			do_close = 1'b1;
		end

		// Tag close.
		if (do_close) begin
			case (tag_class_d)
				TC_ELEM: begin
					if (held_valid_d && held_byte_d == CH_SLASH) begin
						list[cnt] = make_res(EV_SELF_CLOSE, 8'd0, 1'b0, ERR_NONE,
							DEPTH_OUT_W'(nest_d));
						cnt = cnt + 1'b1;
					end else begin
						if (held_valid_d) begin
							list[cnt] = make_res(EV_TAG_BYTE, held_byte_d, 1'b0, ERR_NONE,
								DEPTH_OUT_W'(nest_d));
							cnt = cnt + 1'b1;
						end
						if (nest_d >= DEP_W'(MAX_DEPTH)) begin
							err_d      = 1'b1;
							err_code_d = ERR_TOO_DEEP;
							list[cnt] = make_res(EV_ERROR, 8'd0, 1'b0, ERR_TOO_DEEP,
								DEPTH_OUT_W'(nest_d));
							cnt = cnt + 1'b1;
						end else begin
							nest_d = nest_d + 1'b1;
							list[cnt] = make_res(EV_OPEN_END, 8'd0, 1'b0, ERR_NONE,
								DEPTH_OUT_W'(nest_d));
							cnt = cnt + 1'b1;
						end
					end
				end
				TC_COMMENT: begin
					list[cnt] = make_res(EV_COMMENT, 8'd0, 1'b0, ERR_NONE, DEPTH_OUT_W'(nest_d));
					cnt = cnt + 1'b1;
				end
				TC_DECL: begin
					if (decl_match_d == DECL_FULL) begin
						list[cnt] = make_res(EV_DECL, 8'd0, 1'b0, ERR_NONE, DEPTH_OUT_W'(nest_d));
					end else begin
						err_d      = 1'b1;
						err_code_d = ERR_BAD_DECL;
						list[cnt] = make_res(EV_ERROR, 8'd0, 1'b0, ERR_BAD_DECL,
							DEPTH_OUT_W'(nest_d));
					end
					cnt = cnt + 1'b1;
				end
				TC_END: begin
					if (nest_d == '0) begin
						err_d      = 1'b1;
						err_code_d = ERR_UNMATCHED;
						list[cnt] = make_res(EV_ERROR, 8'd0, 1'b0, ERR_UNMATCHED,
							DEPTH_OUT_W'(nest_d));
					end else begin
						nest_d = nest_d - 1'b1;
						list[cnt] = make_res(EV_END_TAG, 8'd0, 1'b0, ERR_NONE,
							DEPTH_OUT_W'(nest_d));
					end
					cnt = cnt + 1'b1;
				end
				default: begin
					list[cnt] = make_res(EV_EMPTY, 8'd0, 1'b0, ERR_NONE, DEPTH_OUT_W'(nest_d));
					cnt = cnt + 1'b1;
				end
			endcase
			in_tag_d     = 1'b0;
			tag_len_d    = '0;
			cont_len_d   = '0;
			tag_class_d  = TC_NONE;
			held_valid_d = 1'b0;
			held_byte_d  = '0;
			decl_match_d = '0;
		end

		// The end of a document returns everything to its reset value.
		if (beat.last) begin
			in_tag_d     = 1'b0;
			tag_len_d    = '0;
			cont_len_d   = '0;
			nest_d       = '0;
			tag_class_d  = TC_NONE;
			held_byte_d  = '0;
			held_valid_d = 1'b0;
			decl_match_d = '0;
			err_d        = 1'b0;
			err_code_d   = ERR_NONE;
		end

		// Mark the final result of this byte.
		for (int k = 0; k < MAX_RES; k++) begin
			list[k].last_of_run = (cnt != '0) && (RES_CNT_W'(k) == cnt - 1'b1);
		end
	end

	assign res       = list;
	assign res_count = cnt;

	// State registers advance once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tag_q     <= 1'b0;
			tag_len_q    <= '0;
			cont_len_q   <= '0;
			nest_q       <= '0;
			tag_class_q  <= TC_NONE;
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
			decl_match_q <= '0;
			err_q        <= 1'b0;
			err_code_q   <= ERR_NONE;
		end else if (step_en) begin
			in_tag_q     <= in_tag_d;
			tag_len_q    <= tag_len_d;
			cont_len_q   <= cont_len_d;
			nest_q       <= nest_d;
			tag_class_q  <= tag_class_d;
			held_byte_q  <= held_byte_d;
			held_valid_q <= held_valid_d;
			decl_match_q <= decl_match_d;
			err_q        <= err_d;
			err_code_q   <= err_code_d;
		end
	end

endmodule

// File: design/xtt_resq.sv
module xtt_resq import xtt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [RES_CNT_W-1:0] push_count,
	input  out_beat_t            push_data [MAX_RES],
	output logic                 room,
	output logic                 valid,
	input  logic                 stall,
	output out_beat_t            data
);

	localparam int QA_W = $clog2(QDEPTH);
	localparam int QC_W = $clog2(QDEPTH + 1);

	out_beat_t       mem_q [QDEPTH];
	logic [QA_W-1:0] wr_ptr_q;
	logic [QA_W-1:0] rd_ptr_q;
	logic [QC_W-1:0] count_q;
	logic [QC_W-1:0] add;
	logic            pop;

	assign add   = push ? QC_W'(push_count) : '0;
	assign pop   = (count_q != '0) && !stall;
	assign valid = (count_q != '0);
	assign data  = mem_q[rd_ptr_q];

	// Room for a full burst of results, regardless of this cycle's pop.
	assign room  = (count_q <= QC_W'(QDEPTH - MAX_RES));

	// Queue storage.
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_RES; k++) begin
			if (push && RES_CNT_W'(k) < push_count) begin
				mem_q[wr_ptr_q + QA_W'(k)] <= push_data[k];
			end
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QA_W'(add);
			rd_ptr_q <= rd_ptr_q + QA_W'(pop);
			count_q  <= count_q + add - QC_W'(pop);
		end
	end

endmodule

// File: design/xml_tag_tokenizer.sv
// Path: an accepted byte waits in the input register until the result
// queue has room, is then processed by the core, and its results are
// offered from the queue. Throughput: one byte per cycle while the queue
// has room; several results of a byte leave the four-entry queue in turn.
// Reset: arst_n clears parser state, nesting depth, latched error and queue.
module xml_tag_tokenizer import xtt_pkg::*; #(
	parameter int MAX_LEN   = DEF_MAX_LEN,
	parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_beat_t  byte_beat,
	output logic      token_valid,
	input  logic      token_stall,
	output out_beat_t token_beat
);

	logic                 valid_s1;
	in_beat_t             beat_s1;
	logic                 room;
	logic                 step_en;
	logic                 accept;
	out_beat_t            res [MAX_RES];
	logic [RES_CNT_W-1:0] res_count;

	assign step_en    = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign accept     = byte_valid && !byte_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1 <= byte_beat;
		end
	end

	// Parser state and per-byte logic.
	xtt_core #(
		.MAX_LEN   (MAX_LEN),
		.MAX_DEPTH (MAX_DEPTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.beat      (beat_s1),
		.res       (res),
		.res_count (res_count)
	);

	// Result queue feeding the output channel.
	xtt_resq u_resq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (step_en),
		.push_count (res_count),
		.push_data  (res),
		.room       (room),
		.valid      (token_valid),
		.stall      (token_stall),
		.data       (token_beat)
	);

endmodule

// File: design/xtt_checker.sv
module xtt_checker import xtt_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      token_valid,
	input logic      token_stall,
	input out_beat_t token_beat
);

	// A stalled result beat stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> $stable(token_beat))
		else $error("result payload changed while stalled");

	// Error beats carry a code, all other beats carry none.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> ((token_beat.event_res == EV_ERROR) == (token_beat.error_code != ERR_NONE)))
		else $error("error code does not match event");

	// Only byte events carry a value or the kept flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_beat.event_res != EV_CONTENT && token_beat.event_res != EV_TAG_BYTE
		|-> token_beat.value == 8'd0 && !token_beat.kept)
		else $error("non-byte event carries a value");

endmodule

bind xml_tag_tokenizer xtt_checker u_xtt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.token_valid (token_valid),
	.token_stall (token_stall),
	.token_beat  (token_beat)
);
